// File: rtl/vpa_pkg.sv
package vpa_pkg;

    localparam int MAX_SEGMENTS = 32;
    localparam int SIZE_BITS    = 20;
    localparam int JOB_W        = 16;
    localparam int TIME_W       = 32;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int SUM_W        = SIZE_BITS + IDX_W;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 20;

    localparam logic [SIZE_BITS-1:0] TOTAL_RESET = SIZE_BITS'(1024);

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [1:0] OUT_PLACED   = 2'd0;
    localparam logic [1:0] OUT_QUEUED   = 2'd1;
    localparam logic [1:0] OUT_RELEASED = 2'd2;
    localparam logic [1:0] OUT_NONE     = 2'd3;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_MEMORY = CFG_IDX_W'(1);

    typedef struct packed {
        logic                 cmd;
        logic [SIZE_BITS-1:0] job_size;
        logic [JOB_W-1:0]     job_id;
        logic [TIME_W-1:0]    now_time;
        logic [TIME_W-1:0]    run_time;
    } in_item_t;

    typedef struct packed {
        logic [1:0]           outcome;
        logic [JOB_W-1:0]     out_job_id;
        logic [SIZE_BITS-1:0] out_size;
        logic [TIME_W-1:0]    event_time;
        logic [SIZE_BITS-1:0] free_total;
        logic                 external_frag;
        logic                 table_full;
    } out_item_t;

    typedef struct packed {
        logic [SIZE_BITS-1:0] size;
        logic                 busy;
        logic [JOB_W-1:0]     job;
        logic [TIME_W-1:0]    end_time;
    } seg_entry_t;

    localparam int ENTRY_W = $bits(seg_entry_t);

    typedef enum logic [4:0] {
        OP_NONE,
        OP_INIT,
        OP_START,
        OP_SCAN_RD,
        OP_DECIDE,
        OP_SPL_RD,
        OP_SPL_WR,
        OP_PUT_REST,
        OP_PUT_PICK,
        OP_NX_RD,
        OP_NX_EV,
        OP_RM_RD,
        OP_RM_WR,
        OP_RM_END,
        OP_FREE_WR,
        OP_PV_RD,
        OP_PV_EV,
        OP_DONE
    } op_t;

    typedef struct packed {
        logic count_zero;
        logic scan_last;
        logic found;
        logic is_rel;
        logic need_split;
        logic spl_more;
        logic has_next;
        logic has_prev;
        logic rd_free;
        logic rm_more;
        logic out_free;
    } dp_status_t;

endpackage

// File: rtl/variable_partition_allocator_top.sv
// Variable-partition memory allocator with a 32-entry segment table.
// in channel (in_valid/in_ready/in_data): one allocate or release item.
// out channel (out_valid/out_ready/out_data): exactly one result item
//   per input item, in order.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 sets the
//   fit rule, index 1 sets the total size and rebuilds the table as one
//   free segment; other indexes are ignored. Write only while idle.
// Flow: one item at a time. Every item scans the table through the
//   single read port of the table RAM. A split moves each entry behind
//   the chosen one up by one slot, with a check, a read and a write per
//   entry; a release with merges moves entries down the same way, once
//   per merged neighbor.
// Reset: one cycle after reset is spent writing the initial free segment;
//   in_ready stays low during it.
// Stall: the finished result sits in an output register; if it has not
//   been taken, the next item is accepted and processed but waits for the
//   register before finishing.
module variable_partition_allocator_top import vpa_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    op_t        op;
    dp_status_t status;

    // config writes are taken at any time
    assign cfg_ready = 1'b1;

    vpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .op       (op)
    );

    vpa_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// File: rtl/vpa_ram.sv
module vpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/vpa_datapath.sv
module vpa_datapath import vpa_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  op_t                   op,
    input  in_item_t              in_data,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output dp_status_t            status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data
);

    logic [1:0]           fit_mode_reg;
    logic [SIZE_BITS-1:0] total_reg;
    logic [CNT_W-1:0]     count_reg;
    in_item_t             req_reg;
    logic [SIZE_BITS-1:0] js_reg;
    logic [CNT_W-1:0]     idx_reg;
    logic                 rd_v_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     pick_reg;
    seg_entry_t           pick_ent_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [SIZE_BITS-1:0] msize_reg;
    logic                 split_reg;
    logic                 out_valid_reg;
    out_item_t            out_reg;

    logic                 we;
    logic [IDX_W-1:0]     waddr;
    seg_entry_t           wdata;
    logic [IDX_W-1:0]     raddr;
    logic [ENTRY_W-1:0]   rdata_raw;
    seg_entry_t           rdata;

    logic [IDX_W-1:0]     pick_p1;
    logic [IDX_W-1:0]     pick_m1;
    logic [CNT_W-1:0]     pick_ext;
    logic [SIZE_BITS-1:0] rest;
    logic                 is_rel;
    logic                 take;
    logic                 cfg_total;
    logic [SIZE_BITS-1:0] placed_size;
    out_item_t            out_next;

    vpa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SEGMENTS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_raw)
    );

    assign rdata       = seg_entry_t'(rdata_raw);
    assign pick_p1     = pick_reg + IDX_W'(1);
    assign pick_m1     = pick_reg - IDX_W'(1);
    assign pick_ext    = CNT_W'(pick_reg);
    assign rest        = pick_ent_reg.size - js_reg;
    assign is_rel      = (req_reg.cmd == CMD_RELEASE);
    assign cfg_total   = cfg_valid && (cfg_index == REG_TOTAL_MEMORY);
    assign placed_size = split_reg ? js_reg : pick_ent_reg.size;

    // candidate test for the entry coming out of the scan read
    always_comb
    begin
        take = 1'b0;
        if (is_rel)
        begin
            take = rdata.busy && (rdata.end_time <= req_reg.now_time) &&
                   (!found_reg || (rdata.end_time <= pick_ent_reg.end_time));
        end
        else if (!rdata.busy && (rdata.size >= js_reg))
        begin
            priority if (!found_reg)
                take = 1'b1;
            else if (fit_mode_reg == FIT_BEST)
                take = rdata.size < pick_ent_reg.size;
            else if (fit_mode_reg == FIT_WORST)
                take = rdata.size > pick_ent_reg.size;
            else
                take = 1'b0;
        end
    end

    always_comb
    begin
        status.count_zero = (count_reg == '0);
        status.scan_last  = (idx_reg == count_reg - CNT_W'(1));
        status.found      = found_reg;
        status.is_rel     = is_rel;
        status.need_split = (rest != '0) && (count_reg < CNT_W'(MAX_SEGMENTS));
        status.spl_more   = (idx_reg > pick_ext);
        status.has_next   = (pick_ext + CNT_W'(1)) < count_reg;
        status.has_prev   = (pick_reg != '0);
        status.rd_free    = !rdata.busy;
        status.rm_more    = (idx_reg < count_reg);
        status.out_free   = !out_valid_reg || out_ready;
    end

    // table write port
    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        if (cfg_total)
        begin
            we         = 1'b1;
            wdata.size = SIZE_BITS'(cfg_data);
        end
        else
        begin
            unique case (op)
                OP_INIT:
                begin
                    we         = 1'b1;
                    wdata.size = total_reg;
                end
                OP_SPL_WR:
                begin
                    we    = 1'b1;
                    waddr = IDX_W'(idx_reg + CNT_W'(1));
                    wdata = rdata;
                end
                OP_PUT_REST:
                begin
                    we         = 1'b1;
                    waddr      = pick_p1;
                    wdata.size = rest;
                end
                OP_PUT_PICK:
                begin
                    we             = 1'b1;
                    waddr          = pick_reg;
                    wdata.size     = placed_size;
                    wdata.busy     = 1'b1;
                    wdata.job      = req_reg.job_id;
                    wdata.end_time = req_reg.now_time + req_reg.run_time;
                end
                OP_RM_WR:
                begin
                    we    = 1'b1;
                    waddr = IDX_W'(idx_reg - CNT_W'(1));
                    wdata = rdata;
                end
                OP_FREE_WR:
                begin
                    we         = 1'b1;
                    waddr      = pick_reg;
                    wdata.size = msize_reg;
                end
                OP_PV_EV:
                begin
                    we         = !rdata.busy;
                    waddr      = pick_m1;
                    wdata.size = rdata.size + msize_reg;
                end
                default:
                begin
                    we = 1'b0;
                end
            endcase
        end
    end

    // table read port
    always_comb
    begin
        unique case (op)
            OP_SCAN_RD,
            OP_SPL_RD,
            OP_RM_RD:  raddr = idx_reg[IDX_W-1:0];
            OP_NX_RD:  raddr = pick_p1;
            OP_PV_RD:  raddr = pick_m1;
            default:   raddr = '0;
        endcase
    end

    always_comb
    begin
        out_next = '0;
        if (is_rel)
        begin
            if (found_reg)
            begin
                out_next.outcome    = OUT_RELEASED;
                out_next.out_job_id = pick_ent_reg.job;
                out_next.out_size   = pick_ent_reg.size;
                out_next.event_time = pick_ent_reg.end_time;
            end
            else
            begin
                out_next.outcome = OUT_NONE;
            end
        end
        else if (found_reg)
        begin
            out_next.outcome    = OUT_PLACED;
            out_next.out_job_id = req_reg.job_id;
            out_next.out_size   = placed_size;
            out_next.table_full = (rest != '0) && !split_reg;
        end
        else
        begin
            out_next.outcome       = OUT_QUEUED;
            out_next.out_job_id    = req_reg.job_id;
            out_next.free_total    = sum_reg[SIZE_BITS-1:0];
            out_next.external_frag = (sum_reg >= SUM_W'(js_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg  <= FIT_FIRST;
            total_reg     <= TOTAL_RESET;
            count_reg     <= CNT_W'(1);
            rd_v_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg <= (op == OP_SCAN_RD);
            if (cfg_valid && (cfg_index == REG_FIT_MODE))
            begin
                fit_mode_reg <= cfg_data[1:0];
            end
            if (cfg_total)
            begin
                total_reg <= SIZE_BITS'(cfg_data);
                count_reg <= CNT_W'(cfg_data != '0);
            end
            else if (op == OP_INIT)
            begin
                count_reg <= CNT_W'(total_reg != '0);
            end
            else if (op == OP_PUT_REST)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (op == OP_RM_END)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (op == OP_START)
            begin
                found_reg <= 1'b0;
            end
            else if (rd_v_reg && take)
            begin
                found_reg <= 1'b1;
            end
            if (op == OP_DONE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_v_reg && take)
        begin
            pick_reg     <= rd_idx_reg;
            pick_ent_reg <= rdata;
        end
        if (rd_v_reg && !rdata.busy && (op != OP_START))
        begin
            sum_reg <= sum_reg + SUM_W'(rdata.size);
        end
        unique case (op)
            OP_START:
            begin
                req_reg <= in_data;
                js_reg  <= (in_data.job_size == '0) ? SIZE_BITS'(1) : in_data.job_size;
                idx_reg <= '0;
                sum_reg <= '0;
            end
            OP_SCAN_RD:
            begin
                rd_idx_reg <= idx_reg[IDX_W-1:0];
                idx_reg    <= idx_reg + CNT_W'(1);
            end
            OP_DECIDE:
            begin
                idx_reg   <= count_reg - CNT_W'(1);
                msize_reg <= pick_ent_reg.size;
                split_reg <= status.need_split;
            end
            OP_SPL_WR:
            begin
                idx_reg <= idx_reg - CNT_W'(1);
            end
            OP_NX_EV:
            begin
                if (!rdata.busy)
                begin
                    msize_reg <= msize_reg + rdata.size;
                    idx_reg   <= pick_ext + CNT_W'(2);
                end
            end
            OP_RM_WR:
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            OP_PV_EV:
            begin
                idx_reg <= pick_ext + CNT_W'(1);
            end
            OP_DONE:
            begin
                out_reg <= out_next;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: rtl/vpa_ctrl.sv
module vpa_ctrl import vpa_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output op_t        op
);

    typedef enum logic [18:0] {
        S_INIT     = 19'b0000000000000000001,
        S_IDLE     = 19'b0000000000000000010,
        S_SCAN     = 19'b0000000000000000100,
        S_SCAN_END = 19'b0000000000000001000,
        S_DECIDE   = 19'b0000000000000010000,
        S_SPL_CHK  = 19'b0000000000000100000,
        S_SPL_RD   = 19'b0000000000001000000,
        S_SPL_WR   = 19'b0000000000010000000,
        S_PUT_REST = 19'b0000000000100000000,
        S_PUT_PICK = 19'b0000000001000000000,
        S_NX_RD    = 19'b0000000010000000000,
        S_NX_EV    = 19'b0000000100000000000,
        S_RM_CHK   = 19'b0000001000000000000,
        S_RM_RD    = 19'b0000010000000000000,
        S_RM_WR    = 19'b0000100000000000000,
        S_FREE_WR  = 19'b0001000000000000000,
        S_PV_RD    = 19'b0010000000000000000,
        S_PV_EV    = 19'b0100000000000000000,
        S_OUT      = 19'b1000000000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   left_reg;    // removal belongs to the left-hand merge
    logic   left_next;

    always_comb
    begin
        state_next = state_reg;
        left_next  = left_reg;
        op         = OP_NONE;
        unique case (state_reg)
            S_INIT:
            begin
                op         = OP_INIT;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = OP_START;
                    state_next = status.count_zero ? S_SCAN_END : S_SCAN;
                end
            end
            S_SCAN:
            begin
                op = OP_SCAN_RD;
                if (status.scan_last)
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                op = OP_DECIDE;
                priority if (!status.found)
                    state_next = S_OUT;
                else if (!status.is_rel)
                    state_next = status.need_split ? S_SPL_CHK : S_PUT_PICK;
                else
                    state_next = status.has_next ? S_NX_RD : S_FREE_WR;
            end
            S_SPL_CHK:
            begin
                state_next = status.spl_more ? S_SPL_RD : S_PUT_REST;
            end
            S_SPL_RD:
            begin
                op         = OP_SPL_RD;
                state_next = S_SPL_WR;
            end
            S_SPL_WR:
            begin
                op         = OP_SPL_WR;
                state_next = S_SPL_CHK;
            end
            S_PUT_REST:
            begin
                op         = OP_PUT_REST;
                state_next = S_PUT_PICK;
            end
            S_PUT_PICK:
            begin
                op         = OP_PUT_PICK;
                state_next = S_OUT;
            end
            S_NX_RD:
            begin
                op         = OP_NX_RD;
                state_next = S_NX_EV;
            end
            S_NX_EV:
            begin
                op = OP_NX_EV;
                if (status.rd_free)
                begin
                    left_next  = 1'b0;
                    state_next = S_RM_CHK;
                end
                else
                begin
                    state_next = S_FREE_WR;
                end
            end
            S_RM_CHK:
            begin
                if (status.rm_more)
                begin
                    state_next = S_RM_RD;
                end
                else
                begin
                    op         = OP_RM_END;
                    state_next = left_reg ? S_OUT : S_FREE_WR;
                end
            end
            S_RM_RD:
            begin
                op         = OP_RM_RD;
                state_next = S_RM_WR;
            end
            S_RM_WR:
            begin
                op         = OP_RM_WR;
                state_next = S_RM_CHK;
            end
            S_FREE_WR:
            begin
                op         = OP_FREE_WR;
                state_next = status.has_prev ? S_PV_RD : S_OUT;
            end
            S_PV_RD:
            begin
                op         = OP_PV_RD;
                state_next = S_PV_EV;
            end
            S_PV_EV:
            begin
                op = OP_PV_EV;
                if (status.rd_free)
                begin
                    left_next  = 1'b1;
                    state_next = S_RM_CHK;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    op         = OP_DONE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            left_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            left_reg  <= left_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

// File: test/testbench.sv
module testbench;
    import vpa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIMEOUT_CYCLES = 20000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    variable_partition_allocator_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Shadow copy of the allocator: segment table in address order.
    logic [1:0]           mdl_fit;
    logic [SIZE_BITS-1:0] mdl_total;
    seg_entry_t           mdl_seg [MAX_SEGMENTS];
    int                   mdl_count;

    out_item_t expected_results [$];
    int        error_count;
    int        idle_count;
    int        send_gap_pct;
    int        stall_pct;
    bit        hold_off;
    int        hold_cycles;
    logic [31:0] clock_now;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        error_count++;
    endtask

    function automatic void table_rebuild();
        for (int i = 0; i < MAX_SEGMENTS; i++)
            mdl_seg[i] = '0;
        mdl_seg[0].size = mdl_total;
        mdl_count = (mdl_total != 0) ? 1 : 0;
    endfunction

    function automatic void drop_entry(int k);
        for (int i = k; i + 1 < mdl_count; i++)
            mdl_seg[i] = mdl_seg[i+1];
        mdl_count--;
        mdl_seg[mdl_count] = '0;
    endfunction

    // Computes the result of one item and updates the shadow table.
    function automatic out_item_t allocator_predict(in_item_t it);
        out_item_t r;
        logic [SIZE_BITS-1:0] req;
        logic [SIZE_BITS-1:0] rest;
        logic [63:0] sum;
        bit found;
        int pick;
        r = '0;
        found = 0;
        pick = 0;
        if (it.cmd == CMD_ALLOC) begin
            req = (it.job_size == 0) ? SIZE_BITS'(1) : it.job_size;
            for (int i = 0; i < mdl_count; i++) begin
                if (mdl_seg[i].busy || mdl_seg[i].size < req)
                    continue;
                if (!found) begin
                    found = 1;
                    pick = i;
                    if (mdl_fit == FIT_FIRST || mdl_fit == 2'd3)
                        break;
                    continue;
                end
                if (mdl_fit == FIT_BEST && mdl_seg[i].size < mdl_seg[pick].size)
                    pick = i;
                if (mdl_fit == FIT_WORST && mdl_seg[i].size > mdl_seg[pick].size)
                    pick = i;
            end
            if (found) begin
                rest = mdl_seg[pick].size - req;
                if (rest != 0) begin
                    if (mdl_count < MAX_SEGMENTS) begin
                        for (int i = mdl_count; i > pick + 1; i--)
                            mdl_seg[i] = mdl_seg[i-1];
                        mdl_count++;
                        mdl_seg[pick+1] = '0;
                        mdl_seg[pick+1].size = rest;
                        mdl_seg[pick].size = req;
                    end else begin
                        r.table_full = 1'b1;
                    end
                end
                mdl_seg[pick].busy = 1'b1;
                mdl_seg[pick].job = it.job_id;
                mdl_seg[pick].end_time = it.now_time + it.run_time;
                r.outcome = OUT_PLACED;
                r.out_job_id = it.job_id;
                r.out_size = mdl_seg[pick].size;
            end else begin
                sum = 0;
                for (int i = 0; i < mdl_count; i++)
                    if (!mdl_seg[i].busy)
                        sum += mdl_seg[i].size;
                r.outcome = OUT_QUEUED;
                r.out_job_id = it.job_id;
                r.free_total = sum[SIZE_BITS-1:0];
                r.external_frag = (sum >= req);
            end
        end else begin
            for (int i = 0; i < mdl_count; i++) begin
                if (!mdl_seg[i].busy || mdl_seg[i].end_time > it.now_time)
                    continue;
                if (!found || mdl_seg[i].end_time <= mdl_seg[pick].end_time) begin
                    found = 1;
                    pick = i;
                end
            end
            if (!found) begin
                r.outcome = OUT_NONE;
            end else begin
                r.outcome = OUT_RELEASED;
                r.out_job_id = mdl_seg[pick].job;
                r.out_size = mdl_seg[pick].size;
                r.event_time = mdl_seg[pick].end_time;
                mdl_seg[pick].busy = 1'b0;
                mdl_seg[pick].job = '0;
                mdl_seg[pick].end_time = '0;
                if (pick + 1 < mdl_count && !mdl_seg[pick+1].busy) begin
                    mdl_seg[pick].size = mdl_seg[pick].size + mdl_seg[pick+1].size;
                    drop_entry(pick + 1);
                end
                if (pick > 0 && !mdl_seg[pick-1].busy) begin
                    mdl_seg[pick-1].size = mdl_seg[pick-1].size + mdl_seg[pick].size;
                    drop_entry(pick);
                end
            end
        end
        return r;
    endfunction

    // Offers one item with a random lead-in gap and waits for acceptance.
    // Valid stays high until in_ready is high again and then drops; the block is idle then.
    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < send_gap_pct)
            @(posedge clk);
        in_valid <= 1'b1;
        in_data  <= it;
        expected_results.push_back(allocator_predict(it));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_alloc(input logic [SIZE_BITS-1:0] sz, input logic [31:0] now,
                              input logic [31:0] run);
        in_item_t it;
        it.cmd = CMD_ALLOC;
        it.job_size = sz;
        it.job_id = 16'($urandom);
        it.now_time = now;
        it.run_time = run;
        send_item(it);
    endtask

    task automatic send_release(input logic [31:0] now);
        in_item_t it;
        it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
        it.cmd = CMD_RELEASE;
        it.now_time = now;
        send_item(it);
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (140) @(posedge clk);
    endtask

    // Register write, only issued while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_FIT_MODE)
            mdl_fit = val[1:0];
        else if (idx == REG_TOTAL_MEMORY) begin
            mdl_total = val;
            table_rebuild();
        end
    endtask

    // Result checker: compares each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected item", 64'(out_data), 64'd0);
            end else begin
                want = expected_results.pop_front();
                if (out_data.outcome !== want.outcome)
                    report_mismatch("outcome", 64'(out_data.outcome), 64'(want.outcome));
                if (out_data.out_job_id !== want.out_job_id)
                    report_mismatch("out_job_id", 64'(out_data.out_job_id),
                                    64'(want.out_job_id));
                if (out_data.out_size !== want.out_size)
                    report_mismatch("out_size", 64'(out_data.out_size), 64'(want.out_size));
                if (out_data.event_time !== want.event_time)
                    report_mismatch("event_time", 64'(out_data.event_time),
                                    64'(want.event_time));
                if (out_data.free_total !== want.free_total)
                    report_mismatch("free_total", 64'(out_data.free_total),
                                    64'(want.free_total));
                if (out_data.external_frag !== want.external_frag)
                    report_mismatch("external_frag", 64'(out_data.external_frag),
                                    64'(want.external_frag));
                if (out_data.table_full !== want.table_full)
                    report_mismatch("table_full", 64'(out_data.table_full),
                                    64'(want.table_full));
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(posedge clk)
    begin
        if (hold_off) begin
            out_ready <= 1'b0;
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles >= 600)
                hold_off <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog on cycles with no accepted item on any channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count > TIMEOUT_CYCLES) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic set_idling(input int gap, input int stall);
        send_gap_pct = gap;
        stall_pct = stall;
    endtask

    // Extremes of sizes and times, both commands, zero-size request, wrap.
    task automatic test_directed();
        write_reg(REG_FIT_MODE, CFG_DATA_W'(FIT_FIRST));
        send_release(32'd0);
        send_alloc('0, 32'd5, 32'd10);
        send_alloc(20'hFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_alloc(20'd100, 32'hFFFF_FFF0, 32'h20);
        send_alloc(20'd923, 32'd0, 32'd0);
        send_alloc(20'd1, 32'd0, 32'd1);
        send_release(32'hFFFF_FFFF);
        send_release(32'hFFFF_FFFF);
        send_release(32'hFFFF_FFFF);
        send_release(32'hFFFF_FFFF);
        write_reg(REG_TOTAL_MEMORY, 20'hFFFFF);
        send_alloc(20'hFFFFF, 32'd1, 32'd1);
        send_release(32'd2);
        write_reg(REG_TOTAL_MEMORY, 20'd1);
        send_alloc(20'd1, 32'd0, 32'd0);
        send_alloc(20'd1, 32'd0, 32'd0);
        send_release(32'd0);
        write_reg(REG_TOTAL_MEMORY, 20'd0);
        send_alloc(20'd1, 32'd0, 32'd0);
        send_release(32'd0);
        write_reg(2'd3, 20'h5A5A5);
        write_reg(REG_TOTAL_MEMORY, 20'd1024);
    endtask

    // Ties in release order and full table: fill with 1-unit jobs.
    task automatic test_table_full();
        write_reg(REG_TOTAL_MEMORY, 20'd1000);
        for (int i = 0; i < 33; i++)
            send_alloc(20'd1, 32'd0, 32'd7);
        send_release(32'd7);
        send_release(32'd7);
        send_alloc(20'd2, 32'd0, 32'd0);
    endtask

    // Mostly well-formed random traffic under one fit rule.
    task automatic test_random(input logic [1:0] fit, input logic [19:0] total,
                               input int items);
        logic [SIZE_BITS-1:0] sz;
        write_reg(REG_FIT_MODE, CFG_DATA_W'(fit));
        write_reg(REG_TOTAL_MEMORY, total);
        for (int n = 0; n < items; n++) begin
            clock_now += $urandom_range(20);
            if ($urandom_range(99) < 55) begin
                case ($urandom_range(9))
                    0: sz = 20'($urandom);
                    1: sz = total;
                    default: sz = 20'($urandom_range(total / 4 + 1));
                endcase
                send_alloc(sz, clock_now, 32'($urandom_range(60)));
            end else if ($urandom_range(19) == 0) begin
                in_item_t it;
                it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
                send_item(it);
            end else begin
                send_release(clock_now);
            end
        end
    endtask

    task automatic test_pressure();
        write_reg(REG_TOTAL_MEMORY, 20'd4096);
        hold_cycles <= 0;
        hold_off <= 1'b1;
        set_idling(0, 0);
        for (int n = 0; n < 8; n++)
            send_alloc(20'($urandom_range(300, 1)), 32'd0, 32'($urandom));
        wait_drained();
        for (int n = 0; n < 8; n++)
            send_release(32'hFFFF_FFFF);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        idle_count = 0;
        hold_off = 1'b0;
        hold_cycles = 0;
        clock_now = 0;
        set_idling(0, 0);
        mdl_fit = FIT_FIRST;
        mdl_total = TOTAL_RESET;
        table_rebuild();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_table_full();
        set_idling(0, 0);
        test_random(FIT_FIRST, 20'd1024, 80);
        set_idling(52, 0);
        test_random(FIT_BEST, 20'd512, 80);
        set_idling(0, 52);
        test_random(FIT_WORST, 20'hFFFFF, 80);
        set_idling(29, 29);
        test_random(2'd3, 20'd200, 60);
        set_idling(0, 0);
        test_random(FIT_BEST, 20'd64, 70);
        test_pressure();
        set_idling(29, 29);
        test_random(FIT_WORST, 20'd300, 40);

        wait_drained();
        if (error_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
